// ===== hw/rtl/bitp_pkg.sv =====
// Shared types, constants and character helpers for the based integer text parser.
// Depends on nothing; the parse step, result register and top level import it.
`default_nettype none

package bitp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int COUNT_BITS = 12;
    localparam int BASE_BITS  = 6;
    localparam int DIGIT_BITS = 6;

    localparam logic [COUNT_BITS-1:0] END_CAP   = {COUNT_BITS{1'b1}};
    localparam logic [DIGIT_BITS-1:0] NOT_DIGIT = {DIGIT_BITS{1'b1}};

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [1:0] STATUS_BAD_BASE  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;

    typedef struct packed {
        logic [WORD_BITS-1:0]  value;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] offset;
    } result_t;

    function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd99;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
            end else if (c inside {[8'h61:8'h7a]}) begin
                d = c - 8'h61 + 8'd10;
            end else if (c inside {[8'h41:8'h5a]}) begin
                d = c - 8'h41 + 8'd10;
            end
            digit_value = (d == 8'd99) ? NOT_DIGIT : d[DIGIT_BITS-1:0];
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = c inside {8'h20, [8'h09:8'h0d]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bitp_in_stage.sv =====
// Input register of the parser: holds one text byte until the parse step takes it.
// Depends on no other file; it is a plain one-entry stage.
`default_nettype none

module bitp_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_byte,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_char_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitp_parse_step.sv =====
// Parse state of one text and the combinational step that folds in the next byte.
// Depends on bitp_pkg for widths, status codes, the result type and character helpers.
`default_nettype none

module bitp_parse_step (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic [7:0]                     byte_data,
    input  wire logic [bitp_pkg::BASE_BITS-1:0] number_base,
    output logic                                result_valid,
    output bitp_pkg::result_t                   result
);

    import bitp_pkg::*;

    localparam logic [2:0] PH_SKIP     = 3'd0;
    localparam logic [2:0] PH_SIGNED   = 3'd1;
    localparam logic [2:0] PH_ZERO     = 3'd2;
    localparam logic [2:0] PH_ZERO_X   = 3'd3;
    localparam logic [2:0] PH_DIGITS   = 3'd4;
    localparam logic [2:0] PH_STOPPED  = 3'd5;
    localparam logic [2:0] PH_BAD_BASE = 3'd6;

    logic [2:0]            phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [BASE_BITS-1:0]  base_reg, base_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] stop_reg, stop_next;
    logic                  seen_reg, seen_next;

    logic [DIGIT_BITS-1:0]          digit;
    logic                           begin_num;
    logic                           digit_or_stop;
    logic                           take_digit;
    logic [DIGIT_BITS-1:0]          take_val;
    logic [BASE_BITS-1:0]           mul_base;
    logic [WORD_BITS-1:0]           acc_src;
    logic [WORD_BITS+BASE_BITS-1:0] product;
    logic                           is_nul;

    assign digit  = digit_value(byte_data);
    assign is_nul = (byte_data == 8'h00);

    always_comb begin
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        base_next     = base_reg;
        count_next    = count_reg;
        stop_next     = stop_reg;
        seen_next     = seen_reg;
        begin_num     = 1'b0;
        digit_or_stop = 1'b0;
        take_digit    = 1'b0;
        take_val      = digit;
        mul_base      = base_reg;
        acc_src       = acc_reg;
        product       = '0;
        result        = '0;

        case (phase_reg)
            PH_SKIP: begin
                if (is_space(byte_data)) begin
                    phase_next = PH_SKIP;
                end else if (byte_data == 8'h2d) begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGNED;
                end else if (byte_data == 8'h2b) begin
                    phase_next = PH_SIGNED;
                end else begin
                    begin_num = 1'b1;
                end
            end
            PH_SIGNED: begin
                begin_num = 1'b1;
            end
            PH_ZERO: begin
                if (byte_data == 8'h78 || byte_data == 8'h58) begin
                    phase_next = PH_ZERO_X;
                end else begin
                    digit_or_stop = 1'b1;
                end
            end
            PH_ZERO_X: begin
                if (digit < 6'd16) begin
                    base_next  = 6'd16;
                    mul_base   = 6'd16;
                    acc_src    = '0;
                    take_digit = 1'b1;
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_STOPPED;
                end
            end
            PH_DIGITS: begin
                digit_or_stop = 1'b1;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (begin_num) begin
            if (number_base == 6'd1 || number_base > 6'd36) begin
                phase_next = PH_BAD_BASE;
            end else if (byte_data == 8'h30 &&
                         (number_base == 6'd0 || number_base == 6'd16)) begin
                base_next  = (number_base == 6'd0) ? 6'd8 : 6'd16;
                mul_base   = base_next;
                take_val   = '0;
                take_digit = 1'b1;
                phase_next = PH_ZERO;
            end else begin
                base_next     = (number_base == 6'd0) ? 6'd10 : number_base;
                mul_base      = base_next;
                digit_or_stop = 1'b1;
            end
        end

        if (digit_or_stop) begin
            if (digit < mul_base) begin
                take_digit = 1'b1;
                phase_next = PH_DIGITS;
            end else begin
                phase_next = PH_STOPPED;
            end
        end

        if (take_digit) begin
            product   = acc_src * mul_base + (WORD_BITS + BASE_BITS)'(take_val);
            acc_next  = product[WORD_BITS-1:0];
            ovf_next  = ovf_reg || (product[WORD_BITS+BASE_BITS-1:WORD_BITS] != '0);
            seen_next = 1'b1;
            stop_next = (count_reg == END_CAP) ? END_CAP : count_reg + 1'b1;
        end

        if (!is_nul) begin
            if (count_reg != END_CAP) begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (phase_next == PH_BAD_BASE) begin
                result.status = STATUS_BAD_BASE;
            end else if (!seen_next) begin
                result.status = STATUS_NO_DIGITS;
            end else if (ovf_next) begin
                result.value  = '1;
                result.status = STATUS_OVERFLOW;
                result.offset = stop_next;
            end else begin
                result.value  = neg_next ? (~acc_next + 1'b1) : acc_next;
                result.status = STATUS_OK;
                result.offset = stop_next;
            end
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            base_next  = '0;
            count_next = '0;
            stop_next  = '0;
            seen_next  = 1'b0;
        end
    end

    assign result_valid = advance && is_nul;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            base_reg  <= '0;
            count_reg <= '0;
            stop_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            base_reg  <= base_next;
            count_reg <= count_next;
            stop_reg  <= stop_next;
            seen_reg  <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_stop_tracks_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (stop_reg == '0 && acc_reg == '0))
        else $error("stop offset or value set without any digit");

    a_bad_base_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BAD_BASE |-> !seen_reg)
        else $error("digits taken after a bad base");

    a_stop_not_past_count: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg <= count_reg)
        else $error("stop offset lies beyond the bytes counted");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bitp_out_stage.sv =====
// Result register of the parser: holds one finished result word until it is taken.
// Depends on bitp_pkg for the result type.
`default_nettype none

module bitp_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire bitp_pkg::result_t               result,
    output logic                                 can_load,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bitp_pkg::WORD_BITS-1:0]       m_parsed_value,
    output logic [1:0]                           m_parse_status,
    output logic [bitp_pkg::COUNT_BITS-1:0]      m_end_offset
);

    import bitp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load       = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_parsed_value = data_reg.value;
    assign m_parse_status = data_reg.status;
    assign m_end_offset   = data_reg.offset;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/based_integer_text_parser_core.sv =====
// Top level of the based integer text parser: input register, parse step, result register.
// Depends on bitp_pkg, bitp_in_stage, bitp_parse_step and bitp_out_stage.
//
//   Channel   Ports                                          Moves
//   input     s_valid, s_ready, s_char_byte                  one text byte per word
//   result    m_valid, m_ready, m_parsed_value,              one result word per text,
//             m_parse_status, m_end_offset                   given on the NUL byte
//   config    cfg_wr_en, cfg_wr_data                         the number base register
//
// A byte is taken every cycle unless a NUL stalls; it is parsed from the input register.
// The result of a text is shown in the cycle after its NUL byte is parsed.
// The multiply-add of the accumulator by the base sets the length of the step.
// Reset clears the parse state and sets the base to ten; it needs no clearing pass.
// Only a NUL byte waits for the result register, so other bytes pass a stalled output.
`default_nettype none

module based_integer_text_parser_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_char_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bitp_pkg::WORD_BITS-1:0]       m_parsed_value,
    output logic [1:0]                           m_parse_status,
    output logic [bitp_pkg::COUNT_BITS-1:0]      m_end_offset,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bitp_pkg::BASE_BITS-1:0]  cfg_wr_data
);

    import bitp_pkg::*;

    logic [BASE_BITS-1:0] base_reg;
    logic                 byte_valid;
    logic [7:0]           byte_data;
    logic                 take;
    logic                 can_load;
    logic                 result_valid;
    result_t              result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    assign take = byte_valid && (byte_data != 8'h00 || can_load);

    bitp_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .take        (take),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    bitp_parse_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (take),
        .byte_data    (byte_data),
        .number_base  (base_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    bitp_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (result_valid),
        .result         (result),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_parse_status (m_parse_status),
        .m_end_offset   (m_end_offset)
    );

`ifndef SYNTHESIS
    a_nul_waits_for_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && byte_valid && byte_data == 8'h00) |-> !take)
        else $error("NUL byte parsed while the result register is still full");

    a_load_only_on_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |-> (take && byte_data == 8'h00))
        else $error("result produced by a byte that is not NUL");

    a_no_digits_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_parse_status == STATUS_NO_DIGITS ||
                     m_parse_status == STATUS_BAD_BASE))
        |-> (m_parsed_value == '0 && m_end_offset == '0))
        else $error("empty or bad-base result carries a value or offset");

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown straight after reset");
`endif

endmodule

`default_nettype wire
